/* rtl/core/spnbc_pkg.sv */
package spnbc_pkg;

  localparam int unsigned Rounds       = 6;
  localparam int unsigned BlockNibbles = 4;
  localparam int unsigned NibbleBits   = 4;
  localparam int unsigned BlockBits    = BlockNibbles * NibbleBits;
  localparam int unsigned KeyCount     = Rounds + 1;
  localparam int unsigned KeyIdxW      = $clog2(KeyCount + 1);

  typedef logic [BlockBits-1:0]  block_t;
  typedef logic [NibbleBits-1:0] nibble_t;
  typedef block_t [KeyCount-1:0] key_bank_t;
  typedef logic [KeyIdxW-1:0]    key_idx_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_e;

  localparam nibble_t FwdBox [16] = '{
    4'hF, 4'h6, 4'h5, 4'h8, 4'hE, 4'hB, 4'hA, 4'h4,
    4'hC, 4'h0, 4'h3, 4'h7, 4'h2, 4'h9, 4'h1, 4'hD
  };

  localparam nibble_t InvBox [16] = '{
    4'h9, 4'hE, 4'hC, 4'hA, 4'h7, 4'h2, 4'h1, 4'hB,
    4'h3, 4'hD, 4'h6, 4'h5, 4'h8, 4'hF, 4'h4, 4'h0
  };

  // Apply the forward or inverse S-box to every nibble.
  function automatic block_t substitute(input block_t v, input kind_e kind);
    block_t r;
    r = '0;
    for (int n = 0; n < BlockNibbles; n++) begin
      if (kind == KIND_DEC) begin
        r[n*NibbleBits +: NibbleBits] = InvBox[v[n*NibbleBits +: NibbleBits]];
      end else begin
        r[n*NibbleBits +: NibbleBits] = FwdBox[v[n*NibbleBits +: NibbleBits]];
      end
    end
    return r;
  endfunction

  // Swap bit NibbleBits*i+j with bit NibbleBits*j+i (4x4 bit matrix transpose).
  function automatic block_t transpose(input block_t v);
    block_t r;
    r = '0;
    for (int i = 0; i < BlockNibbles; i++) begin
      for (int j = 0; j < NibbleBits; j++) begin
        r[i*NibbleBits + j] = v[j*NibbleBits + i];
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/spn_block_cipher_16bit.sv */
// Channel  | Direction | Signals                                   | Beat content
// ---------+-----------+-------------------------------------------+---------------------------
// in       | input     | in_valid_i, in_ready_o, kind_i, block_in_i | mode bit and 16-bit block
// out      | output    | out_valid_o, out_ready_i, block_out_o      | 16-bit result block
// cfg      | input     | cfg_valid_i, cfg_ready_o, cfg_index_i,    | subkey index and value
//          |           | cfg_data_i                                 |
//
// The accepted input beat is held in the input register, then passes through the six
// unrolled rounds into the result register, which drives the result beat.
// One block per cycle while the output is not stalled; the round chain is the critical path.
// Reset clears both valid flags and all subkeys to zero.
// A stalled output holds its beat; the input register still takes a beat whenever
// it is empty or can move its block into the result register.
module spn_block_cipher_16bit (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input blocks
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [15:0]         block_in_i,
  // result blocks
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         block_out_o,
  // subkey writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  spnbc_pkg::key_idx_t cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int unsigned Rounds = spnbc_pkg::Rounds;

  spnbc_pkg::key_bank_t subkeys;

  // Input register.
  logic              s1_valid_q, s1_valid_d;
  spnbc_pkg::kind_e  s1_kind_q;
  spnbc_pkg::block_t s1_block_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  spnbc_pkg::block_t out_block_q;

  logic              in_fire;
  logic              s1_advance;
  spnbc_pkg::block_t pre_key;
  spnbc_pkg::block_t post_key;
  spnbc_pkg::block_t result;
  spnbc_pkg::block_t chain [Rounds+1];

  // Subkeys are always writable; the user must write them only while the block is idle (unchecked).
  assign cfg_ready_o = 1'b1;

  spnbc_keys u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .subkeys_o (subkeys)
  );

  // Advance the held block when the result register is free or being drained.
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Whitening key goes first when decrypting and last when encrypting.
  assign pre_key  = (s1_kind_q == spnbc_pkg::KIND_DEC) ? subkeys[Rounds] : '0;
  assign post_key = (s1_kind_q == spnbc_pkg::KIND_ENC) ? subkeys[Rounds] : '0;

  assign chain[0] = s1_block_q ^ pre_key;

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    spnbc_pkg::block_t rnd_subkey;
    // Decryption walks the subkeys in reverse order.
    assign rnd_subkey = (s1_kind_q == spnbc_pkg::KIND_DEC) ? subkeys[Rounds-1-r]
                                                          : subkeys[r];
    spnbc_round u_round (
      .kind_i   (s1_kind_q),
      .block_i  (chain[r]),
      .subkey_i (rnd_subkey),
      .block_o  (chain[r+1])
    );
  end

  assign result = chain[Rounds] ^ post_key;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load when their stage takes a block, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= spnbc_pkg::kind_e'(kind_i);
      s1_block_q <= block_in_i;
    end
    if (s1_advance) begin
      out_block_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_out_o = out_block_q;

endmodule

/* rtl/core/spnbc_round.sv */
module spnbc_round (
  input  spnbc_pkg::kind_e  kind_i,
  input  spnbc_pkg::block_t block_i,
  input  spnbc_pkg::block_t subkey_i,
  output spnbc_pkg::block_t block_o
);

  spnbc_pkg::block_t enc_out;
  spnbc_pkg::block_t dec_out;

  // Encrypt: key mix, substitute, transpose. Decrypt runs the inverse order.
  assign enc_out = spnbc_pkg::transpose(
                     spnbc_pkg::substitute(block_i ^ subkey_i, spnbc_pkg::KIND_ENC));
  assign dec_out = spnbc_pkg::substitute(spnbc_pkg::transpose(block_i),
                                         spnbc_pkg::KIND_DEC) ^ subkey_i;

  assign block_o = (kind_i == spnbc_pkg::KIND_DEC) ? dec_out : enc_out;

endmodule

/* rtl/core/spnbc_keys.sv */
module spnbc_keys (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  spnbc_pkg::key_idx_t   wr_idx_i,
  input  spnbc_pkg::block_t     wr_data_i,
  output spnbc_pkg::key_bank_t  subkeys_o
);

  spnbc_pkg::key_bank_t keys_q;
  spnbc_pkg::key_bank_t keys_d;

  // Drop writes to indexes past the last subkey.
  always_comb begin
    keys_d = keys_q;
    for (int k = 0; k < spnbc_pkg::KeyCount; k++) begin
      if (wr_en_i && (wr_idx_i == spnbc_pkg::key_idx_t'(k))) begin
        keys_d[k] = wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
    end else begin
      keys_q <= keys_d;
    end
  end

  assign subkeys_o = keys_q;

endmodule
